// File: hdl/vrle_pkg.sv
// package for the voxel run-length decoder
// widths, header bit positions and the run result type; no dependencies
package vrle_pkg;

	// field widths
	localparam int CODE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int POS_W   = 16;
	localparam int LEN_W   = 17;
	localparam int HI_W    = 4;
	localparam int SHORT_W = 5;

	// packed stream widths, tdata filled up to whole bytes
	localparam int M_DATA_W = ((POS_W + LEN_W + 7) / 8) * 8;
	localparam int M_USER_W = 8;

	// chunk size register
	localparam logic [LEN_W-1:0] VOXEL_COUNT_RESET = 17'h10000;
	localparam logic [LEN_W-1:0] POS_SPAN          = 17'h10000;
	localparam int               MAX_VOXELS_DEF    = 65536;

	// header byte layout
	localparam int KIND_LSB = 6;
	localparam int LONG_BIT = 5;
	localparam int NULL_BIT = 4;

	// block kinds
	localparam logic [KIND_W-1:0] KIND_AIR = 2'd0;

	// one decoded run
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  length;
		logic              done;
	} run_t;

endpackage

// File: hdl/vrle_decode.sv
// header decode, chunk fill state and run clipping for the voxel decoder
// depends on vrle_pkg
module vrle_decode import vrle_pkg::*; #(
	parameter int MAX_VOXELS = MAX_VOXELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data,
	input  logic              fire,
	input  logic [CODE_W-1:0] code,
	output logic              emit,
	output run_t              run
);

	// largest chunk that the position counter can address
	localparam logic [LEN_W-1:0] CAP =
		(MAX_VOXELS < 65536) ? LEN_W'(MAX_VOXELS) : POS_SPAN;

	logic [LEN_W-1:0]  voxel_count_q;
	logic [POS_W-1:0]  fill_q;
	logic              await_q;
	logic [KIND_W-1:0] held_kind_q;
	logic [HI_W-1:0]   held_hi_q;

	logic [LEN_W-1:0]  lim;
	logic [LEN_W-1:0]  pos;
	logic [LEN_W-1:0]  room;
	logic [LEN_W-1:0]  count;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  pos_next;
	logic [KIND_W-1:0] kind;
	logic              is_run;
	logic              hold;
	logic              done;

	// effective chunk size and start of the next run
	always_comb begin
		if (voxel_count_q == '0) begin
			lim = LEN_W'(1);
		end else if (voxel_count_q > CAP) begin
			lim = CAP;
		end else begin
			lim = voxel_count_q;
		end
		pos  = ({1'b0, fill_q} >= lim) ? '0 : {1'b0, fill_q};
		room = lim - pos;
	end

	// header decode: low byte of a long run, terminator, short, long or null header
	always_comb begin
		kind   = code[KIND_LSB +: KIND_W];
		count  = '0;
		is_run = 1'b0;
		hold   = 1'b0;
		priority if (await_q) begin
			kind   = held_kind_q;
			count  = LEN_W'({held_hi_q, code});
			is_run = 1'b1;
		end else if (code == '0) begin
			kind   = KIND_AIR;
			count  = room;
			is_run = 1'b1;
		end else if (!code[LONG_BIT]) begin
			count  = LEN_W'(code[SHORT_W-1:0]);
			is_run = 1'b1;
		end else if (!code[NULL_BIT]) begin
			hold   = 1'b1;
		end else begin
			is_run = 1'b0;
		end
	end

	// clip at the chunk end
	always_comb begin
		len      = (count < room) ? count : room;
		done     = (len == room);
		pos_next = pos + len;
		emit     = is_run && (count != '0);
	end

	assign run.kind   = kind;
	assign run.start  = pos[POS_W-1:0];
	assign run.length = len;
	assign run.done   = done;

	// chunk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxel_count_q <= VOXEL_COUNT_RESET;
			fill_q        <= '0;
			await_q       <= 1'b0;
			held_kind_q   <= '0;
			held_hi_q     <= '0;
		end else if (cfg_wr_en) begin
			voxel_count_q <= cfg_wr_data;
			fill_q        <= '0;
			await_q       <= 1'b0;
		end else if (fire) begin
			await_q <= hold;
			if (hold) begin
				held_kind_q <= kind;
				held_hi_q   <= code[HI_W-1:0];
			end
			if (emit) begin
				fill_q <= done ? '0 : pos_next[POS_W-1:0];
			end
		end
	end

	// the fill position stays inside the chunk once it has been consumed
	a_fill_in_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && !cfg_wr_en |=> ({1'b0, fill_q} < lim))
		else $error("fill position outside chunk");

	// a run that ends the chunk restarts it at index zero
	a_done_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && done && !cfg_wr_en |=> (fill_q == '0))
		else $error("chunk not restarted after fill");

	// a configuration write drops a pending long header
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (!await_q && fill_q == '0))
		else $error("config write left decode state");

	// an emitted run never passes the chunk end
	a_run_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (pos + len <= lim))
		else $error("run passes chunk end");

endmodule

// File: hdl/voxel_rle_run_decoder_unit.sv
// top level of the voxel run-length decoder: input word register, decode, result register
// depends on vrle_pkg and vrle_decode
//
// Decodes a stream of run-length code bytes into voxel runs of one block kind each,
// given as a linear start index, a length clipped at the chunk end, and tlast when
// the run fills the chunk or a zero header terminates it. One byte is taken every
// cycle while the run stream is not stalled; a result word passes the input word
// register, the single decode stage and the result register before it turns valid
// on the master side, and bytes that give no run (long header, null header, zero
// count) produce no word. While the master side is stalled, the result register
// holds and the input word register takes a byte only while it is empty. The chunk
// size register may be written only while no byte is in flight; a write restarts
// the chunk at index zero.
module voxel_rle_run_decoder_unit import vrle_pkg::*; #(
	parameter int MAX_VOXELS = MAX_VOXELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// chunk size register, voxel_count
	input  logic                cfg_wr_en,
	input  logic [LEN_W-1:0]    cfg_wr_data,
	// code byte stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [CODE_W-1:0]   s_tdata,   // [7:0] code_byte
	// run stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [15:0] run_start, [32:16] run_length
	output logic [M_USER_W-1:0] m_tuser,   // [1:0] block_kind
	output logic                m_tlast    // chunk_done
);

	logic              v_s1;
	logic [CODE_W-1:0] code_s1;
	logic              adv;
	logic              fire;
	logic              emit;
	run_t              run;
	run_t              run_q;

	// pipeline advance
	assign adv      = !m_tvalid || m_tready;
	assign fire     = v_s1 && adv;
	assign s_tready = !v_s1 || adv;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_s1 <= s_tdata;
		end
	end

	// decode stage
	vrle_decode #(
		.MAX_VOXELS(MAX_VOXELS)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.code        (code_s1),
		.emit        (emit),
		.run         (run)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			run_q <= run;
		end
	end

	// pack the output word
	assign m_tdata = M_DATA_W'({run_q.length, run_q.start});
	assign m_tuser = M_USER_W'(run_q.kind);
	assign m_tlast = run_q.done;

	// a result word never carries an empty run
	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (run_q.length != '0))
		else $error("empty run on output");

endmodule
